/* rtl/ostb_pkg.sv */
// ----------------------------------------------------------------------------
// ostb_pkg
// Shared types and constants of the one-shot timer bank: opcodes, the
// stored timer entry and the command/status groups between controller
// and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ostb_pkg;

  // Field widths
  localparam int OP_W   = 3;
  localparam int IDX_FW = 8;
  localparam int TICK_W = 32;

  // Opcodes
  localparam logic [OP_W-1:0] OP_ARM     = 3'd0;
  localparam logic [OP_W-1:0] OP_RESTART = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd2;
  localparam logic [OP_W-1:0] OP_SCAN    = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

  // Most results one scan may report
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS);

  // One stored timer
  typedef struct packed {
    logic [TICK_W-1:0] start_tick;
    logic [TICK_W-1:0] deadline_tick;
    logic [TICK_W-1:0] reload_ticks;
  } ostb_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // latch item, issue first entry read
    logic single_go;  // execute non-scan op and load its result
    logic scan_step;  // evaluate current timer, advance
    logic final_go;   // load closing scan result
  } ostb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_scan;    // offered item is a scan
    logic hit;        // current timer is armed and expired
    logic at_end;     // current timer is the last one
    logic cap;        // this hit reaches the result limit
    logic pend_valid; // a fired result is held back
    logic out_free;   // output register can take a result now
  } ostb_sts_t;

endpackage

`default_nettype wire

/* rtl/ostb_ctrl.sv */
// ----------------------------------------------------------------------------
// ostb_ctrl
// Sequencer of the timer bank: takes one item, runs a single-entry operation
// or scans the bank one timer per cycle while no held-back result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module ostb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ostb_pkg::ostb_sts_t sts,
  output ostb_pkg::ostb_cmd_t     cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SINGLE = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINAL  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Take an item only from idle
  assign in_stall = (state_r != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.in_scan ? ST_SCAN : ST_SINGLE;
        end
      end
      ST_SINGLE: begin
        if (sts.out_free) begin
          cmd.single_go = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // hold only when a held-back result must go out and cannot
        if (!(sts.hit && sts.pend_valid && !sts.out_free)) begin
          cmd.scan_step = 1'b1;
          if ((sts.hit && sts.cap) || sts.at_end) begin
            state_nxt = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        if (sts.out_free) begin
          cmd.final_go = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/ostb_dp.sv */
// ----------------------------------------------------------------------------
// ostb_dp
// Datapath of the timer bank: item registers, armed flags, entry memory
// with a registered read port, scan counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ostb_dp #(
  parameter int NUM_TIMERS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ostb_pkg::ostb_cmd_t           cmd,
  output ostb_pkg::ostb_sts_t                sts,
  input  wire logic [ostb_pkg::OP_W-1:0]     in_opcode,
  input  wire logic [ostb_pkg::IDX_FW-1:0]   in_timer_index,
  input  wire logic [ostb_pkg::TICK_W-1:0]   in_timeout_ticks,
  input  wire logic [ostb_pkg::TICK_W-1:0]   in_current_tick,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output logic                               out_status,
  output logic                               out_is_active,
  output logic                               out_fired,
  output logic [ostb_pkg::IDX_FW-1:0]        out_fired_timer,
  output logic                               out_last
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // Item registers
  logic [ostb_pkg::OP_W-1:0]   op_r;
  logic                        ok_r;
  logic [IDX_W-1:0]            t_r;
  logic [ostb_pkg::TICK_W-1:0] tmo_r;
  logic [ostb_pkg::TICK_W-1:0] cur_r;

  // Timer state
  logic [NUM_TIMERS-1:0]       armed_r;
  ostb_pkg::ostb_entry_t       mem [NUM_TIMERS];
  ostb_pkg::ostb_entry_t       rd_r;

  // Scan state
  logic [IDX_W-1:0]                 scan_idx_r;
  logic [ostb_pkg::RES_CNT_W-1:0]   cnt_r;
  logic                             pend_vld_r;
  logic [IDX_W-1:0]                 pend_idx_r;

  // Result register
  logic                        out_valid_r;
  logic                        status_r;
  logic                        active_r;
  logic                        fired_r;
  logic [ostb_pkg::IDX_FW-1:0] fired_idx_r;
  logic                        last_r;

  // Decode of the offered item
  logic             in_ok;
  logic [IDX_W-1:0] in_t;
  logic             in_scan;

  assign in_ok   = (in_timer_index < ostb_pkg::IDX_FW'(NUM_TIMERS));
  assign in_t    = in_ok ? in_timer_index[IDX_W-1:0] : '0;
  assign in_scan = (in_opcode == ostb_pkg::OP_SCAN);

  // Expiry of the timer under scan, wrap aware
  logic at_end, cur_armed, expired, hit, out_free;
  logic [ostb_pkg::TICK_W-1:0] s_tick, d_tick;

  assign s_tick    = rd_r.start_tick;
  assign d_tick    = rd_r.deadline_tick;
  assign at_end    = (scan_idx_r == IDX_W'(NUM_TIMERS - 1));
  assign cur_armed = armed_r[scan_idx_r];
  assign expired   = (s_tick > d_tick) ? ((cur_r < s_tick) && (cur_r >= d_tick))
                                       : ((cur_r < s_tick) || (cur_r >= d_tick));
  assign hit       = cur_armed && expired;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    sts.in_scan    = in_scan;
    sts.hit        = hit;
    sts.at_end     = at_end;
    sts.cap        = (cnt_r == ostb_pkg::RES_CNT_W'(ostb_pkg::MAX_RESULTS - 1));
    sts.pend_valid = pend_vld_r;
    sts.out_free   = out_free;
  end

  // Read port address: addressed timer or first timer on accept, next timer in scan
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  assign rd_en   = cmd.accept || (cmd.scan_step && !at_end);
  assign rd_addr = cmd.accept ? (in_scan ? '0 : in_t) : (scan_idx_r + IDX_W'(1));

  // Operation effects and result selection
  logic                        armed_t;
  logic                        wr_en;
  ostb_pkg::ostb_entry_t       wr_data;
  logic                        arm_set, arm_clr, scan_clr;
  logic                        push, push_status, push_active, push_fired, push_last;
  logic [ostb_pkg::IDX_FW-1:0] push_idx;

  assign armed_t = armed_r[t_r];

  always_comb begin
    wr_en       = 1'b0;
    wr_data     = rd_r;
    arm_set     = 1'b0;
    arm_clr     = 1'b0;
    scan_clr    = 1'b0;
    push        = 1'b0;
    push_status = 1'b0;
    push_active = 1'b0;
    push_fired  = 1'b0;
    push_idx    = '0;
    push_last   = 1'b0;
    if (cmd.single_go) begin
      push      = 1'b1;
      push_last = 1'b1;
      unique case (op_r)
        ostb_pkg::OP_ARM: begin
          push_status = !ok_r;
          if (ok_r && (tmo_r != '0)) begin
            wr_en   = 1'b1;
            wr_data = '{start_tick: cur_r, deadline_tick: cur_r + tmo_r,
                        reload_ticks: tmo_r};
            arm_set = 1'b1;
          end else if (ok_r) begin
            arm_clr = 1'b1;
          end
        end
        ostb_pkg::OP_RESTART: begin
          push_status = !ok_r;
          if (ok_r && armed_t) begin
            wr_en   = 1'b1;
            wr_data = '{start_tick: cur_r, deadline_tick: cur_r + rd_r.reload_ticks,
                        reload_ticks: rd_r.reload_ticks};
          end
        end
        ostb_pkg::OP_CLEAR: begin
          push_status = !ok_r;
          arm_clr     = ok_r;
        end
        ostb_pkg::OP_QUERY: begin
          push_status = !ok_r;
          push_active = ok_r && armed_t;
        end
        default: ;
      endcase
    end else if (cmd.scan_step) begin
      // release the held-back result once a later one is known
      if (hit) begin
        scan_clr   = 1'b1;
        push       = pend_vld_r;
        push_fired = 1'b1;
        push_idx   = ostb_pkg::IDX_FW'(pend_idx_r);
      end
    end else if (cmd.final_go) begin
      push       = 1'b1;
      push_last  = 1'b1;
      push_fired = pend_vld_r;
      push_idx   = pend_vld_r ? ostb_pkg::IDX_FW'(pend_idx_r) : '0;
    end
  end

  // Entry memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[t_r] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_opcode;
      ok_r  <= in_ok;
      t_r   <= in_t;
      tmo_r <= in_timeout_ticks;
      cur_r <= in_current_tick;
    end
  end

  // Armed flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= '0;
    end else begin
      if (arm_set) begin
        armed_r[t_r] <= 1'b1;
      end
      if (arm_clr) begin
        armed_r[t_r] <= 1'b0;
      end
      if (scan_clr) begin
        armed_r[scan_idx_r] <= 1'b0;
      end
    end
  end

  // Scan walk, hit count and held-back result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      cnt_r      <= '0;
      pend_vld_r <= 1'b0;
    end else if (cmd.accept) begin
      scan_idx_r <= '0;
      cnt_r      <= '0;
      pend_vld_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!at_end) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
      if (hit) begin
        cnt_r      <= cnt_r + ostb_pkg::RES_CNT_W'(1);
        pend_vld_r <= 1'b1;
        pend_idx_r <= scan_idx_r;
      end
    end else if (cmd.final_go) begin
      pend_vld_r <= 1'b0;
    end
  end

  // Result register: load on push, drop after transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      status_r    <= push_status;
      active_r    <= push_active;
      fired_r     <= push_fired;
      fired_idx_r <= push_idx;
      last_r      <= push_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_is_active   = active_r;
  assign out_fired       = fired_r;
  assign out_fired_timer = fired_idx_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire

/* rtl/one_shot_timer_bank.sv */
// Bank of NUM_TIMERS one-shot timers clocked by a wrapping 32-bit tick that
// arrives with every command. One command is in the block at a time. Arm,
// restart, clear and query are taken, then executed once the result
// register is free, and give one result. Scan walks the timers through the
// single read port of the entry memory, one timer per cycle unless a
// held-back result waits on a stalled output, and gives one result per
// expired timer (at most 16, in index order) or a single no-fire result;
// the last one carries out_last. The result register lets a finished
// result wait while the next command is taken.
// ----------------------------------------------------------------------------
// one_shot_timer_bank
// Top level: controller and datapath of the one-shot timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

module one_shot_timer_bank #(
  parameter int NUM_TIMERS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [ostb_pkg::OP_W-1:0]   in_opcode,
  input  wire logic [ostb_pkg::IDX_FW-1:0] in_timer_index,
  input  wire logic [ostb_pkg::TICK_W-1:0] in_timeout_ticks,
  input  wire logic [ostb_pkg::TICK_W-1:0] in_current_tick,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_status,
  output logic                             out_is_active,
  output logic                             out_fired,
  output logic [ostb_pkg::IDX_FW-1:0]      out_fired_timer,
  output logic                             out_last
);

  ostb_pkg::ostb_cmd_t cmd;
  ostb_pkg::ostb_sts_t sts;

  ostb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ostb_dp #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_timer_index   (in_timer_index),
    .in_timeout_ticks (in_timeout_ticks),
    .in_current_tick  (in_current_tick),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_is_active    (out_is_active),
    .out_fired        (out_fired),
    .out_fired_timer  (out_fired_timer),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

/* rtl/ostb_checker.sv */
// ----------------------------------------------------------------------------
// ostb_checker
// Port-level checks of the one-shot timer bank, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ostb_checker #(
  parameter int NUM_TIMERS = 16
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic                        out_status,
  input wire logic                        out_is_active,
  input wire logic                        out_fired,
  input wire logic [ostb_pkg::IDX_FW-1:0] out_fired_timer,
  input wire logic                        out_last
);

  // One command at a time: a transfer closes the input for the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a command is in progress");

  // Only scan results are ever non-final, and each reports a fired timer
  a_nonlast_fired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_fired && !out_status && !out_is_active)
    else $error("non-final result that is not a fired timer");

  // A fired timer index lies inside the bank
  a_fired_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fired |-> (out_fired_timer < ostb_pkg::IDX_FW'(NUM_TIMERS)))
    else $error("fired timer index outside the bank");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fired_timer)
                               && $stable(out_last) && $stable(out_fired))
    else $error("stalled result changed");

endmodule

bind one_shot_timer_bank ostb_checker #(.NUM_TIMERS(NUM_TIMERS)) u_ostb_checker (.*);

`default_nettype wire

/* tb/tb_one_shot_timer_bank.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_one_shot_timer_bank
// Self-checking bench for the one-shot timer bank. A directed run covers
// arm, restart, clear, query and scan at the field extremes, wrapped
// deadlines, bad indexes and unused opcodes. A random run follows, with a
// drifting tick and small timeouts so that scans fire often. Every accepted
// command updates a shadow copy of the timers, which predicts the results in
// order. Sender gaps and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------

import ostb_pkg::*;

localparam int NUM_TIMERS = 16;

// Opcodes outside the defined set
localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 3'd7;

// Result status codes
localparam logic STATUS_DONE      = 1'b0;
localparam logic STATUS_BAD_INDEX = 1'b1;

class timer_bank_scoreboard;

  typedef struct {
    logic              status;
    logic              is_active;
    logic              fired;
    logic [IDX_FW-1:0] fired_timer;
    logic              last;
  } timer_result_t;

  // Shadow copy of the timer bank
  bit                armed[NUM_TIMERS];
  bit [TICK_W-1:0]   start_tick[NUM_TIMERS];
  bit [TICK_W-1:0]   deadline_tick[NUM_TIMERS];
  bit [TICK_W-1:0]   reload_ticks[NUM_TIMERS];

  timer_result_t     expected_results[$];
  int                mismatches;

  task report(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function bit has_expired(input int t, input bit [TICK_W-1:0] cur);
    // Deadline wrapped past zero: fire only inside the wrapped window
    if (start_tick[t] > deadline_tick[t]) begin
      return (cur < start_tick[t]) && (cur >= deadline_tick[t]);
    end
    return (cur < start_tick[t]) || (cur >= deadline_tick[t]);
  endfunction

  function void push_single(input logic status, input logic is_active);
    timer_result_t r;
    r = '{status, is_active, 1'b0, '0, 1'b1};
    expected_results.push_back(r);
  endfunction

  // Update the shadow bank for one accepted command and queue its results
  function void note_command(input logic [OP_W-1:0] op, input logic [IDX_FW-1:0] idx,
                             input logic [TICK_W-1:0] tmo, input logic [TICK_W-1:0] cur);
    bit            in_range;
    int            t;
    int            fired_count;
    timer_result_t r;
    in_range = (idx < NUM_TIMERS);
    t = in_range ? int'(idx) : 0;
    case (op)
      OP_ARM: begin
        if (in_range && tmo != '0) begin
          armed[t] = 1'b1;
          start_tick[t] = cur;
          deadline_tick[t] = cur + tmo;
          reload_ticks[t] = tmo;
        end else if (in_range) begin
          armed[t] = 1'b0;
          start_tick[t] = '0;
          deadline_tick[t] = '0;
          reload_ticks[t] = '0;
        end
        push_single(in_range ? STATUS_DONE : STATUS_BAD_INDEX, 1'b0);
      end
      OP_RESTART: begin
        // Only an active timer is re-armed
        if (in_range && armed[t]) begin
          start_tick[t] = cur;
          deadline_tick[t] = cur + reload_ticks[t];
        end
        push_single(in_range ? STATUS_DONE : STATUS_BAD_INDEX, 1'b0);
      end
      OP_CLEAR: begin
        if (in_range) begin
          armed[t] = 1'b0;
          start_tick[t] = '0;
          deadline_tick[t] = '0;
          reload_ticks[t] = '0;
        end
        push_single(in_range ? STATUS_DONE : STATUS_BAD_INDEX, 1'b0);
      end
      OP_SCAN: begin
        // Visit in index order, disarm and report each expired timer; keep reload
        fired_count = 0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (fired_count < MAX_RESULTS && armed[i] && has_expired(i, cur)) begin
            armed[i] = 1'b0;
            start_tick[i] = '0;
            deadline_tick[i] = '0;
            r = '{STATUS_DONE, 1'b0, 1'b1, IDX_FW'(i), 1'b0};
            expected_results.push_back(r);
            fired_count++;
          end
        end
        if (fired_count == 0) begin
          push_single(STATUS_DONE, 1'b0);
        end else begin
          expected_results[expected_results.size() - 1].last = 1'b1;
        end
      end
      OP_QUERY: begin
        push_single(in_range ? STATUS_DONE : STATUS_BAD_INDEX, in_range && armed[t]);
      end
      default: begin
        push_single(STATUS_DONE, 1'b0);
      end
    endcase
  endfunction

  // Compare one result transfer against the oldest expectation
  task check_result(input logic status, input logic is_active, input logic fired,
                    input logic [IDX_FW-1:0] fired_timer, input logic last);
    timer_result_t e;
    if (expected_results.size() == 0) begin
      report($sformatf("unexpected result st=%b act=%b fired=%b timer=%0d last=%b",
                       status, is_active, fired, fired_timer, last));
    end else begin
      e = expected_results.pop_front();
      if (status !== e.status || is_active !== e.is_active || fired !== e.fired ||
          fired_timer !== e.fired_timer || last !== e.last) begin
        report($sformatf({"got st=%b act=%b fired=%b timer=%0d last=%b, ",
                          "want st=%b act=%b fired=%b timer=%0d last=%b"},
                         status, is_active, fired, fired_timer, last,
                         e.status, e.is_active, e.fired, e.fired_timer, e.last));
      end
    end
  endtask

endclass

module tb_one_shot_timer_bank;

  localparam int STALL_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_opcode = '0;
  logic [IDX_FW-1:0] in_timer_index = '0;
  logic [TICK_W-1:0] in_timeout_ticks = '0;
  logic [TICK_W-1:0] in_current_tick = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_status;
  logic              out_is_active;
  logic              out_fired;
  logic [IDX_FW-1:0] out_fired_timer;
  logic              out_last;

  timer_bank_scoreboard sb;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  int                   quiet_cycles = 0;
  logic [TICK_W-1:0]    tick_now;

  one_shot_timer_bank #(.NUM_TIMERS(NUM_TIMERS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_timer_index   (in_timer_index),
    .in_timeout_ticks (in_timeout_ticks),
    .in_current_tick  (in_current_tick),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_is_active    (out_is_active),
    .out_fired        (out_fired),
    .out_fired_timer  (out_fired_timer),
    .out_last         (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random receiver backpressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Check result transfers; stop the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_status, out_is_active, out_fired, out_fired_timer, out_last);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Offer one command after an optional gap and hold it until the transfer
  task automatic send_command(input logic [OP_W-1:0] op, input logic [IDX_FW-1:0] idx,
                              input logic [TICK_W-1:0] tmo, input logic [TICK_W-1:0] cur);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_timer_index   <= idx;
    in_timeout_ticks <= tmo;
    in_current_tick  <= cur;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(op, idx, tmo, cur);
  endtask

  // Mostly in-range commands on a drifting tick, with short timeouts
  task automatic send_random_command();
    logic [OP_W-1:0]   op;
    logic [IDX_FW-1:0] idx;
    logic [TICK_W-1:0] tmo;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) op = OP_ARM;
    else if (pick < 45) op = OP_RESTART;
    else if (pick < 55) op = OP_CLEAR;
    else if (pick < 80) op = OP_SCAN;
    else if (pick < 95) op = OP_QUERY;
    else op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    if ($urandom_range(0, 9) == 0) idx = IDX_FW'($urandom_range(NUM_TIMERS, (1 << IDX_FW) - 1));
    else idx = IDX_FW'($urandom_range(0, NUM_TIMERS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 5) tmo = '0;
    else if (pick < 10) tmo = $urandom;
    else tmo = $urandom_range(1, 40);
    // Jump the tick now and then so that pending timers fire together
    if ($urandom_range(0, 99) < 4) tick_now = $urandom;
    else tick_now = tick_now + $urandom_range(0, 8);
    send_command(op, idx, tmo, tick_now);
  endtask

  initial begin
    sb = new();
    tick_now = $urandom;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed commands
    send_command(OP_QUERY,   8'd0,   32'd0,          32'd0);
    send_command(OP_ARM,     8'd0,   32'd10,         32'd100);
    send_command(OP_ARM,     8'd15,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
    send_command(OP_ARM,     8'd16,  32'd5,          32'd100);
    send_command(OP_ARM,     8'd255, 32'd5,          32'd100);
    send_command(OP_QUERY,   8'd0,   32'd0,          32'd101);
    send_command(OP_QUERY,   8'd200, 32'd0,          32'd101);
    send_command(OP_RESTART, 8'd3,   32'd0,          32'd102);
    send_command(OP_RESTART, 8'd0,   32'd0,          32'd105);
    send_command(OP_SCAN,    8'd0,   32'd0,          32'd110);
    send_command(OP_RESTART, 8'd16,  32'd0,          32'd111);
    send_command(OP_CLEAR,   8'd99,  32'd0,          32'd112);
    send_command(OP_SCAN,    8'd77,  32'hFFFF_FFFF,  32'd115);
    send_command(OP_ARM,     8'd5,   32'h20,         32'hFFFF_FFF0);
    send_command(OP_SCAN,    8'd0,   32'd0,          32'hFFFF_FFF8);
    send_command(OP_SCAN,    8'd0,   32'd0,          32'h10);
    send_command(OP_ARM,     8'd7,   32'd50,         32'd200);
    send_command(OP_CLEAR,   8'd7,   32'd0,          32'd201);
    send_command(OP_RESTART, 8'd7,   32'd0,          32'd202);
    send_command(OP_ARM,     8'd8,   32'd0,          32'd203);
    send_command(OP_SCAN,    8'd0,   32'd0,          32'hFFFF_FFFE);
    send_command(OP_FIRST_UNUSED,           8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(OP_W'(OP_FIRST_UNUSED + 1), 8'd0,   32'd0,         32'd0);
    send_command(OP_LAST_UNUSED,            8'd3,   32'd9,         32'd300);

    // Random commands across the idling phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      repeat (19) send_random_command();
    end

    // Drain outstanding results, then allow for any stray ones
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4 * NUM_TIMERS) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
